/* hdl/slf_pkg.sv */
// ============================================================================
// slf_pkg: shared types, constants and tables of the stereo ladder filter
// holds the beat structs, register indexes, the sequencer states and the
// tanh, 2^f and one-pole coefficient tables built at elaboration
// ============================================================================
package slf_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int TAB_BITS    = 10;
    localparam int TAB_DEPTH   = 1 << TAB_BITS;
    localparam int TAB_ABITS   = TAB_BITS + 1;
    localparam int NPROC       = (CHANNELS < 2) ? CHANNELS : 2;
    localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_BITS    = 18;
    localparam int DIV_BITS    = 48;
    localparam int DEN_BITS    = 18;
    localparam int DCNT_BITS   = $clog2(DIV_BITS + 1);
    localparam int MULB_BITS   = 32;

    localparam int Q30_UP    = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
    localparam int Q30_DN    = (SAMPLE_BITS > 31) ? SAMPLE_BITS - 31 : 0;
    localparam int OUT_SHIFT = 43 - SAMPLE_BITS;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [31:0] FB_GAIN   = 32'd288358;
    localparam logic [17:0] PCT_DIV   = 18'd20;
    localparam logic [63:0] LIM_MUL   = 64'd589824;
    localparam logic [63:0] CUT_MIN   = 64'd20 << 16;
    localparam logic [63:0] CUT_MAX   = 64'd20000 << 16;
    localparam logic [63:0] PCT_ROUND = 64'd19;

    typedef logic signed [63:0] wide_t;
    typedef logic [31:0] tab_t [0:TAB_DEPTH];

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic signed [SAMPLE_BITS-1:0] mod_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        REG_BASE_CUTOFF = 3'd0,
        REG_RESONANCE   = 3'd1,
        REG_DRIVE       = 3'd2,
        REG_MOD_DEPTH   = 3'd3,
        REG_VOLUME      = 3'd4,
        REG_MODE        = 3'd5,
        REG_SAMPLE_RATE = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_LP12 = 2'd0,
        MODE_LP24 = 2'd1,
        MODE_HP12 = 2'd2,
        MODE_HP24 = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        TAB_TANH = 2'd0,
        TAB_EXP2 = 2'd1,
        TAB_COEF = 2'd2
    } tab_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PCT,
        ST_EDIV,
        ST_EXP,
        ST_FC,
        ST_LIM,
        ST_POS,
        ST_COEF,
        ST_GSAVE,
        ST_DRIVE,
        ST_FB1,
        ST_FB2,
        ST_TANH,
        ST_XSIGN,
        ST_STAGE,
        ST_OUT,
        ST_NEXT,
        ST_DONE,
        ST_IP_LO,
        ST_IP_HI,
        ST_IP_DIFF,
        ST_IP_MUL
    } state_t;

    function automatic wide_t to_q30(input logic signed [SAMPLE_BITS-1:0] s);
        wide_t w;
        w = wide_t'(s);
        return (w <<< Q30_UP) >>> Q30_DN;
    endfunction

    // restoring long division, only used while the tables are built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-w), w in q30: series at w/16, then squared four times
    function automatic logic [63:0] exp_neg(input logic [63:0] w);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        y    = w >> 4;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n < 60; n++)
        begin
            if (term != 64'd0)
            begin
                term = udiv64((term * y) >> 30, 64'(n));
                sum  = sum + term;
            end
        end
        r = udiv64((64'd1 << 60) + (sum >> 1), sum);
        for (int i = 0; i < 4; i++)
        begin
            r = (r * r + (64'd1 << 29)) >> 30;
        end
        return r;
    endfunction

    function automatic tab_t build_tab(input tab_sel_t sel);
        tab_t t;
        logic [63:0] e;
        logic [63:0] v;
        for (int i = 0; i <= TAB_DEPTH; i++)
        begin
            case (sel)
                TAB_TANH:
                begin
                    e = exp_neg(((64'd16 * 64'(i)) << 30) >> TAB_BITS);
                    t[i] = 32'(udiv64(((ONE_Q30 - e) << 30) + ((ONE_Q30 + e) >> 1),
                                      ONE_Q30 + e));
                end
                TAB_EXP2:
                begin
                    v = exp_neg((LN2_Q30 * 64'(i)) >> TAB_BITS);
                    t[i] = 32'(udiv64((64'd1 << 60) + (v >> 1), v));
                end
                default:
                begin
                    t[i] = 32'(ONE_Q30 - exp_neg((PI_Q30 * 64'(i)) >> TAB_BITS));
                end
            endcase
        end
        return t;
    endfunction

    localparam tab_t TANH_TAB = build_tab(TAB_TANH);
    localparam tab_t EXP2_TAB = build_tab(TAB_EXP2);
    localparam tab_t COEF_TAB = build_tab(TAB_COEF);

endpackage

/* hdl/stereo_ladder_filter_core.sv */
// ============================================================================
// stereo_ladder_filter_core: four-pole saturating ladder filter, stereo
// one sequencer drives a shared bit-serial multiplier and divider
// ============================================================================
// sample channel: sample_valid / sample_stall carry one beat of left, right
// and cutoff-modulation samples. result channel: result_valid / result_stall
// carry one beat of filtered left and right samples per input beat.
// configuration: cfg_write, cfg_index and cfg_data write one register per
// clock; write only while no beat is in flight.
// the processing time of a beat, from acceptance to result_valid, depends
// on the register values, the data and result_stall. it is set by the
// multiplier, which retires one multiplier bit per cycle (up to 22 products
// per beat), and by the divider, which runs three divisions per beat.
// one beat is processed at a time; sample_stall is low only while idle.
// the finished result sits in an output register, so a new sample beat is
// taken while the previous result still waits on a stalled receiver; the
// sequencer holds its finished beat until that register is free.
// reset (rst_n low) clears all filter stages to zero, loads the register
// defaults and drops result_valid.
// ============================================================================
module stereo_ladder_filter_core
    import slf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  in_beat_t            sample_data,
    output logic                result_valid,
    input  logic                result_stall,
    output out_beat_t           result_data,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    // configuration
    logic [14:0] base_cutoff_reg;
    logic [16:0] resonance_reg;
    logic [14:0] drive_reg;
    logic [7:0]  mod_depth_reg;
    logic [12:0] volume_reg;
    logic [1:0]  mode_reg;
    logic [17:0] sample_rate_reg;

    // sequencer
    state_t state_reg, state_next;
    state_t ret_reg;
    logic   launched_reg, launched_next;
    logic [CH_BITS-1:0] chan_reg;
    logic [1:0]         stg_reg;
    logic               op_done;
    logic               launch_state;
    logic               use_div;

    // filter state
    logic signed [31:0] lvl_reg [0:3][0:CHANNELS-1];
    logic signed [31:0] lvl_rd;
    logic [1:0]         rd_stg;

    // working registers
    in_beat_t  smp_reg;
    wide_t     prod_reg;
    wide_t     e_reg;
    logic [63:0] fc_reg;
    logic [63:0] ipos_reg;
    tab_sel_t  tab_sel_reg;
    logic [31:0] ip_res_reg;
    logic [31:0] lo_reg;
    logic [31:0] diff_reg;
    logic        hi_ge_reg;
    logic [31:0] g_reg;
    wide_t     dr_reg;
    wide_t     fb_reg;
    wide_t     u_reg;
    wide_t     x_reg;
    wide_t     cur_reg;
    wide_t     s2_reg;
    wide_t     s4_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg;
    logic signed [SAMPLE_BITS-1:0] res_r_reg;
    logic        result_valid_reg;
    out_beat_t   result_data_reg;

    // table read port
    logic [TAB_ABITS-1:0] rom_addr;
    logic [31:0]          rom_q_reg;
    logic [47:0]          ip_idx;
    logic                 ip_over;
    logic [TAB_ABITS-1:0] lo_addr;
    logic [TAB_ABITS-1:0] hi_addr;

    // bit-serial multiplier
    wide_t                mul_a_reg;
    wide_t                mul_acc_reg;
    logic [MULB_BITS-1:0] mul_b_reg;
    logic                 mul_neg_reg;
    logic                 mul_busy_reg;
    logic                 mul_start;
    wide_t                mul_a_in;
    logic [MULB_BITS-1:0] mul_b_in;
    logic                 mul_neg_in;

    // bit-serial divider
    logic [DIV_BITS-1:0]  div_num_reg;
    logic [DEN_BITS-1:0]  div_rem_reg;
    logic [DEN_BITS-1:0]  div_den_reg;
    logic [DCNT_BITS-1:0] div_cnt_reg;
    logic                 div_busy_reg;
    logic                 div_start;
    logic [DIV_BITS-1:0]  div_num_in;
    logic [DEN_BITS-1:0]  div_den_in;
    logic [DEN_BITS:0]    div_trial;

    // derived values
    logic [8:0]  pct_mag;
    logic [17:0] fs_eff;
    wide_t       ei;
    wide_t       ei_neg;
    logic [63:0] fc_base;
    logic [63:0] fc_shift;
    logic [63:0] fc_clamp;
    logic [63:0] u_mag;
    wide_t       y_sel;
    wide_t       stage_v;
    wide_t       out_v;
    logic signed [SAMPLE_BITS-1:0] out_sat;
    logic signed [SAMPLE_BITS-1:0] chan_smp;
    logic [31:0] rom_hi;

    localparam wide_t SAT_MAX = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - wide_t'(1);
    localparam wide_t SAT_MIN = -(wide_t'(1) <<< (SAMPLE_BITS - 1));

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    assign op_done = launched_reg && !mul_busy_reg && !div_busy_reg;
    assign rd_stg  = (state_reg == ST_FB1) ? 2'd3 : stg_reg;
    assign lvl_rd  = lvl_reg[rd_stg][chan_reg];

    assign pct_mag  = mod_depth_reg[7] ? (9'd0 - {1'b1, mod_depth_reg})
                                       : {1'b0, mod_depth_reg};
    assign fs_eff   = (sample_rate_reg == 18'd0) ? 18'd1 : sample_rate_reg;
    assign chan_smp = (chan_reg == '0) ? smp_reg.left_in : smp_reg.right_in;

    assign ip_idx  = ipos_reg[63:16];
    assign ip_over = (ip_idx >= 48'(TAB_DEPTH));
    assign lo_addr = ip_over ? TAB_ABITS'(TAB_DEPTH) : ip_idx[TAB_ABITS-1:0];
    assign hi_addr = ip_over ? TAB_ABITS'(TAB_DEPTH) : ip_idx[TAB_ABITS-1:0] + 1'b1;
    assign rom_hi  = rom_q_reg;

    // cutoff shift by the integer part of the exponent
    assign ei       = e_reg >>> 30;
    assign ei_neg   = -ei;
    assign fc_base  = 64'(mul_acc_reg) >> 14;
    assign fc_shift = e_reg[63] ? (fc_base >> ei_neg[3:0]) : (fc_base << ei[3:0]);
    assign fc_clamp = (fc_shift < CUT_MIN) ? CUT_MIN
                    : ((fc_shift > CUT_MAX) ? CUT_MAX : fc_shift);

    assign u_mag   = u_reg[63] ? 64'(-u_reg) : 64'(u_reg);
    assign stage_v = wide_t'(lvl_rd) + (mul_acc_reg >>> 30);
    assign out_v   = mul_acc_reg >>> OUT_SHIFT;
    assign out_sat = (out_v > SAT_MAX) ? SAMPLE_BITS'(SAT_MAX)
                   : ((out_v < SAT_MIN) ? SAMPLE_BITS'(SAT_MIN)
                                        : out_v[SAMPLE_BITS-1:0]);

    always_comb
    begin
        case (mode_t'(mode_reg))
            MODE_LP12: y_sel = s2_reg;
            MODE_LP24: y_sel = s4_reg;
            MODE_HP12: y_sel = x_reg - s2_reg;
            default:   y_sel = x_reg - s4_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (sample_valid) state_next = ST_PCT;
            ST_PCT:     if (op_done) state_next = ST_EDIV;
            ST_EDIV:    if (op_done) state_next = ST_EXP;
            ST_EXP:     state_next = ST_IP_LO;
            ST_FC:      if (op_done) state_next = ST_LIM;
            ST_LIM:     if (op_done) state_next = ST_POS;
            ST_POS:     if (op_done) state_next = ST_COEF;
            ST_COEF:    state_next = ST_IP_LO;
            ST_GSAVE:   state_next = ST_DRIVE;
            ST_DRIVE:   if (op_done) state_next = ST_FB1;
            ST_FB1:     if (op_done) state_next = ST_FB2;
            ST_FB2:     if (op_done) state_next = ST_TANH;
            ST_TANH:    state_next = ST_IP_LO;
            ST_XSIGN:   state_next = ST_STAGE;
            ST_STAGE:   if (op_done && stg_reg == 2'd3) state_next = ST_OUT;
            ST_OUT:     if (op_done) state_next = ST_NEXT;
            ST_NEXT:    state_next = (chan_reg == CH_BITS'(NPROC - 1)) ? ST_DONE : ST_DRIVE;
            ST_DONE:    if (!result_valid_reg || !result_stall) state_next = ST_IDLE;
            ST_IP_LO:   state_next = ST_IP_HI;
            ST_IP_HI:   state_next = ST_IP_DIFF;
            ST_IP_DIFF: state_next = ip_over ? ret_reg : ST_IP_MUL;
            ST_IP_MUL:  if (op_done) state_next = ret_reg;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit control and operands
    always_comb
    begin
        launch_state = 1'b0;
        use_div      = 1'b0;
        mul_a_in     = '0;
        mul_b_in     = '0;
        mul_neg_in   = 1'b0;
        div_num_in   = '0;
        div_den_in   = PCT_DIV;
        rom_addr     = lo_addr;
        case (state_reg)
            ST_PCT:
            begin
                launch_state = 1'b1;
                mul_a_in     = to_q30(smp_reg.mod_in);
                mul_b_in     = MULB_BITS'(pct_mag);
                mul_neg_in   = mod_depth_reg[7];
            end
            ST_EDIV:
            begin
                launch_state = 1'b1;
                use_div      = 1'b1;
                div_num_in   = prod_reg[63] ? DIV_BITS'(64'(-prod_reg) + PCT_ROUND)
                                            : DIV_BITS'(prod_reg);
                div_den_in   = PCT_DIV;
            end
            ST_FC:
            begin
                launch_state = 1'b1;
                mul_a_in     = wide_t'({32'd0, ip_res_reg});
                mul_b_in     = MULB_BITS'(base_cutoff_reg);
            end
            ST_LIM:
            begin
                launch_state = 1'b1;
                use_div      = 1'b1;
                div_num_in   = DIV_BITS'(64'(fs_eff) * LIM_MUL);
                div_den_in   = PCT_DIV;
            end
            ST_POS:
            begin
                launch_state = 1'b1;
                use_div      = 1'b1;
                div_num_in   = DIV_BITS'(fc_reg << (TAB_BITS + 1));
                div_den_in   = fs_eff;
            end
            ST_DRIVE:
            begin
                launch_state = 1'b1;
                mul_a_in     = to_q30(chan_smp);
                mul_b_in     = MULB_BITS'(drive_reg);
            end
            ST_FB1:
            begin
                launch_state = 1'b1;
                mul_a_in     = wide_t'(lvl_rd);
                mul_b_in     = MULB_BITS'(resonance_reg);
            end
            ST_FB2:
            begin
                launch_state = 1'b1;
                mul_a_in     = fb_reg;
                mul_b_in     = FB_GAIN;
            end
            ST_STAGE:
            begin
                launch_state = 1'b1;
                mul_a_in     = cur_reg - wide_t'(lvl_rd);
                mul_b_in     = g_reg;
            end
            ST_OUT:
            begin
                launch_state = 1'b1;
                mul_a_in     = y_sel;
                mul_b_in     = MULB_BITS'(volume_reg);
            end
            ST_IP_HI:
            begin
                rom_addr = hi_addr;
            end
            ST_IP_MUL:
            begin
                launch_state = 1'b1;
                mul_a_in     = wide_t'({32'd0, diff_reg});
                mul_b_in     = MULB_BITS'(ipos_reg[15:0]);
            end
            default:
            begin
                launch_state = 1'b0;
            end
        endcase
        mul_start = launch_state && !launched_reg && !use_div;
        div_start = launch_state && !launched_reg && use_div;
        if (!launch_state)
        begin
            launched_next = 1'b0;
        end
        else if (!launched_reg)
        begin
            launched_next = 1'b1;
        end
        else
        begin
            launched_next = !op_done;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            launched_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            mul_busy_reg     <= 1'b0;
            div_busy_reg     <= 1'b0;
            base_cutoff_reg  <= 15'd1000;
            resonance_reg    <= 17'd13107;
            drive_reg        <= 15'd4096;
            mod_depth_reg    <= 8'd0;
            volume_reg       <= 13'd4096;
            mode_reg         <= MODE_LP24;
            sample_rate_reg  <= 18'd48000;
            for (int s = 0; s < 4; s++)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    lvl_reg[s][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE_CUTOFF: base_cutoff_reg <= cfg_data[14:0];
                    REG_RESONANCE:   resonance_reg   <= cfg_data[16:0];
                    REG_DRIVE:       drive_reg       <= cfg_data[14:0];
                    REG_MOD_DEPTH:   mod_depth_reg   <= cfg_data[7:0];
                    REG_VOLUME:      volume_reg      <= cfg_data[12:0];
                    REG_MODE:        mode_reg        <= cfg_data[1:0];
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[17:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_DONE && (!result_valid_reg || !result_stall))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
            end
            else if (mul_busy_reg && mul_b_reg == '0)
            begin
                mul_busy_reg <= 1'b0;
            end

            if (div_start)
            begin
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg && div_cnt_reg == DCNT_BITS'(1))
            begin
                div_busy_reg <= 1'b0;
            end

            if (state_reg == ST_STAGE && op_done)
            begin
                lvl_reg[stg_reg][chan_reg] <= stage_v[31:0];
            end
        end
    end

    // multiplier: one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_a_reg   <= mul_a_in;
            mul_b_reg   <= mul_b_in;
            mul_neg_reg <= mul_neg_in;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mul_b_reg == '0)
            begin
                if (mul_neg_reg)
                begin
                    mul_acc_reg <= -mul_acc_reg;
                end
            end
            else
            begin
                if (mul_b_reg[0])
                begin
                    mul_acc_reg <= mul_acc_reg + mul_a_reg;
                end
                mul_a_reg <= mul_a_reg <<< 1;
                mul_b_reg <= mul_b_reg >> 1;
            end
        end
    end

    // restoring divider: one quotient bit per cycle
    assign div_trial = {div_rem_reg, div_num_reg[DIV_BITS-1]};

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_num_reg <= div_num_in;
            div_den_reg <= div_den_in;
            div_rem_reg <= '0;
            div_cnt_reg <= DCNT_BITS'(DIV_BITS);
        end
        else if (div_busy_reg)
        begin
            if (div_trial >= {1'b0, div_den_reg})
            begin
                div_rem_reg <= DEN_BITS'(div_trial - {1'b0, div_den_reg});
                div_num_reg <= {div_num_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[DEN_BITS-1:0];
                div_num_reg <= {div_num_reg[DIV_BITS-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // table read, registered
    always_ff @(posedge clk)
    begin
        case (tab_sel_reg)
            TAB_TANH: rom_q_reg <= TANH_TAB[rom_addr];
            TAB_EXP2: rom_q_reg <= EXP2_TAB[rom_addr];
            default:  rom_q_reg <= COEF_TAB[rom_addr];
        endcase
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    smp_reg   <= sample_data;
                    res_l_reg <= '0;
                    res_r_reg <= '0;
                    chan_reg  <= '0;
                end
            end
            ST_PCT:
            begin
                if (op_done) prod_reg <= mul_acc_reg;
            end
            ST_EDIV:
            begin
                if (op_done)
                begin
                    e_reg <= prod_reg[63] ? -wide_t'({16'd0, div_num_reg})
                                          : wide_t'({16'd0, div_num_reg});
                end
            end
            ST_EXP:
            begin
                ipos_reg    <= ({34'd0, e_reg[29:0]} << TAB_BITS) >> 14;
                tab_sel_reg <= TAB_EXP2;
                ret_reg     <= ST_FC;
            end
            ST_FC:
            begin
                if (op_done) fc_reg <= fc_clamp;
            end
            ST_LIM:
            begin
                if (op_done && fc_reg > 64'(div_num_reg)) fc_reg <= 64'(div_num_reg);
            end
            ST_POS:
            begin
                if (op_done) ipos_reg <= 64'(div_num_reg);
            end
            ST_COEF:
            begin
                tab_sel_reg <= TAB_COEF;
                ret_reg     <= ST_GSAVE;
            end
            ST_GSAVE:
            begin
                g_reg    <= ip_res_reg;
                chan_reg <= '0;
            end
            ST_DRIVE:
            begin
                if (op_done) dr_reg <= mul_acc_reg >>> 12;
            end
            ST_FB1:
            begin
                if (op_done) fb_reg <= mul_acc_reg >>> 16;
            end
            ST_FB2:
            begin
                if (op_done) u_reg <= dr_reg - (mul_acc_reg >>> 16);
            end
            ST_TANH:
            begin
                ipos_reg    <= (u_mag << TAB_BITS) >> 17;
                tab_sel_reg <= TAB_TANH;
                ret_reg     <= ST_XSIGN;
            end
            ST_XSIGN:
            begin
                x_reg   <= u_reg[63] ? -wide_t'({32'd0, ip_res_reg})
                                     : wide_t'({32'd0, ip_res_reg});
                cur_reg <= u_reg[63] ? -wide_t'({32'd0, ip_res_reg})
                                     : wide_t'({32'd0, ip_res_reg});
                stg_reg <= 2'd0;
            end
            ST_STAGE:
            begin
                if (op_done)
                begin
                    cur_reg <= stage_v;
                    stg_reg <= stg_reg + 1'b1;
                    if (stg_reg == 2'd1) s2_reg <= stage_v;
                    if (stg_reg == 2'd3) s4_reg <= stage_v;
                end
            end
            ST_OUT:
            begin
                if (op_done)
                begin
                    if (chan_reg == '0) res_l_reg <= out_sat;
                    else res_r_reg <= out_sat;
                end
            end
            ST_NEXT:
            begin
                chan_reg <= chan_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_data_reg.left_out  <= res_l_reg;
                    result_data_reg.right_out <= res_r_reg;
                end
            end
            ST_IP_HI:
            begin
                lo_reg <= rom_q_reg;
            end
            ST_IP_DIFF:
            begin
                if (ip_over)
                begin
                    ip_res_reg <= lo_reg;
                end
                hi_ge_reg <= (rom_hi >= lo_reg);
                diff_reg  <= (rom_hi >= lo_reg) ? rom_hi - lo_reg : lo_reg - rom_hi;
            end
            ST_IP_MUL:
            begin
                if (op_done)
                begin
                    ip_res_reg <= hi_ge_reg ? lo_reg + mul_acc_reg[47:16]
                                            : lo_reg - mul_acc_reg[47:16];
                end
            end
            default: ;
        endcase
    end

endmodule
